[hdl/sfs_pkg.sv]
// sfs_pkg: shared types, codes and constants of the sprite frame sequencer
// request and result structs, configuration struct, command codes
// no dependencies
package sfs_pkg;

    localparam int MAX_FRAMES_DEF = 256;
    localparam int Q_DEPTH        = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [20:0] ACC_MAX = 21'h1FFFFF;
    localparam logic [17:0] XY_MAX  = 18'h3FFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_ROW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_START      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_END        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_PONG      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD   = 3'd7;

    // request mode codes
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_STOP   = 3'd2;
    localparam logic [2:0] MODE_PAUSE  = 3'd3;
    localparam logic [2:0] MODE_RESUME = 3'd4;

    localparam logic [19:0] PERIOD_RST = 20'd100000;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_TICK,
        CMD_START,
        CMD_STOP,
        CMD_PAUSE,
        CMD_RESUME
    } t_cmd;

    typedef struct packed {
        logic [2:0]  mode;
        logic [19:0] elapsed;
    } t_in_item;

    typedef struct packed {
        logic        playing;
        logic [7:0]  frame_number;
        logic [17:0] frame_x;
        logic [17:0] frame_y;
    } t_out_item;

    typedef struct packed {
        t_cmd        cmd;
        logic [19:0] elapsed;
    } t_q_entry;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [8:0]  frames_per_row;
        logic [7:0]  seq_start;
        logic [7:0]  seq_end;
        logic        ping_pong;
        logic        loop_enable;
        logic [19:0] frame_period;
    } t_cfg;

endpackage

[hdl/sfs_front.sv]
// sfs_front: accepts requests, decodes the mode into a command
// and holds decoded commands in a short queue for the back end
// depends on sfs_pkg
module sfs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sfs_pkg::t_in_item i_in_data,
    output logic              o_q_valid,
    output sfs_pkg::t_q_entry o_q_entry,
    input  logic              i_q_pop
);
    import sfs_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_q_entry       r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_count, n_count;
    logic           w_push;
    logic           w_pop;
    t_q_entry       w_entry;

    always_comb begin
        w_entry.elapsed = i_in_data.elapsed;
        case (i_in_data.mode)
            MODE_TICK:   w_entry.cmd = CMD_TICK;
            MODE_START:  w_entry.cmd = CMD_START;
            MODE_STOP:   w_entry.cmd = CMD_STOP;
            MODE_PAUSE:  w_entry.cmd = CMD_PAUSE;
            MODE_RESUME: w_entry.cmd = CMD_RESUME;
            default:     w_entry.cmd = CMD_NOP;
        endcase
    end

    assign o_in_stall = (r_count == QCW'(Q_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_entry  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

endmodule

[hdl/sfs_back.sv]
// sfs_back: executes queued commands, keeps the playback state,
// finds the sheet row and column by an iterative divide and scales them
// depends on sfs_pkg
module sfs_back #(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfs_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  sfs_pkg::t_q_entry  i_q_entry,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sfs_pkg::t_out_item o_out_data
);
    import sfs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ACC   = 7'b0000010,
        S_STEP  = 7'b0000100,
        S_FRAME = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    function automatic logic [7:0] clamp_frame(input logic [7:0] f);
        logic [7:0] res;
        res = f;
        if (int'(f) > MAX_FRAMES - 1) begin
            res = 8'(MAX_FRAMES - 1);
        end
        return res;
    endfunction

    function automatic logic [17:0] sat_xy(input logic [18:0] v);
        return v[18] ? XY_MAX : v[17:0];
    endfunction

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [19:0] r_elapsed, n_elapsed;
    logic [20:0] r_sum, n_sum;
    logic [20:0] r_acc, n_acc;
    logic [9:0]  r_pos, n_pos;
    logic        r_running, n_running;
    logic [7:0]  r_frame, n_frame;
    logic [8:0]  r_rem, n_rem;
    logic [7:0]  r_quo, n_quo;
    logic [2:0]  r_div_cnt, n_div_cnt;
    logic [18:0] r_x_prod, n_x_prod;
    logic [18:0] r_y_prod, n_y_prod;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic [7:0]  w_a, w_b, w_d;
    logic [9:0]  w_len;
    logic [19:0] w_period;
    logic [8:0]  w_fpr;
    logic [21:0] w_sum_wide;
    logic [10:0] w_pos_inc;
    logic [9:0]  w_p;
    logic [9:0]  w_off;
    logic [7:0]  w_frame;
    logic [9:0]  w_trial;
    logic        w_qbit;

    // sequence geometry from configuration
    always_comb begin
        w_a = clamp_frame(i_cfg.seq_start);
        w_b = clamp_frame(i_cfg.seq_end);
        w_d = (w_a > w_b) ? (w_a - w_b) : (w_b - w_a);
        if (w_d == '0) begin
            w_len = '0;
        end else if (!i_cfg.ping_pong) begin
            w_len = {2'b00, w_d} + 10'd1;
        end else if (i_cfg.loop_enable) begin
            w_len = {1'b0, w_d, 1'b0};
        end else begin
            w_len = {1'b0, w_d, 1'b0} + 10'd1;
        end
        w_period = (i_cfg.frame_period == '0) ? 20'd1 : i_cfg.frame_period;
        w_fpr    = (i_cfg.frames_per_row == '0) ? 9'd1 : i_cfg.frames_per_row;
    end

    always_comb begin
        w_sum_wide = {1'b0, r_acc} + {2'b00, r_elapsed};
        w_pos_inc  = {1'b0, r_pos} + 11'd1;
        w_p        = (r_pos >= w_len) ? (w_len - 10'd1) : r_pos;
        w_off      = (w_p <= {2'b00, w_d}) ? w_p : ({1'b0, w_d, 1'b0} - w_p);
        if (w_len == '0) begin
            w_frame = w_a;
        end else if (w_b >= w_a) begin
            w_frame = w_a + w_off[7:0];
        end else begin
            w_frame = w_a - w_off[7:0];
        end
        w_trial = {r_rem, r_quo[7]};
        w_qbit  = (w_trial >= {1'b0, w_fpr});
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_elapsed   = r_elapsed;
        n_sum       = r_sum;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_running   = r_running;
        n_frame     = r_frame;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div_cnt   = r_div_cnt;
        n_x_prod    = r_x_prod;
        n_y_prod    = r_y_prod;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_cmd     = i_q_entry.cmd;
                    n_elapsed = i_q_entry.elapsed;
                    n_state   = S_ACC;
                end
            end
            S_ACC: begin
                n_sum   = w_sum_wide[21] ? ACC_MAX : w_sum_wide[20:0];
                n_state = S_STEP;
            end
            S_STEP: begin
                case (r_cmd)
                    CMD_TICK: begin
                        if (r_running) begin
                            if (w_len == '0) begin
                                n_running = 1'b0;
                                n_pos     = '0;
                            end else begin
                                n_acc = r_sum;
                                if (r_sum >= {1'b0, w_period}) begin
                                    n_acc = r_sum - {1'b0, w_period};
                                    if (w_pos_inc >= {1'b0, w_len}) begin
                                        if (i_cfg.loop_enable) begin
                                            n_pos = '0;
                                        end else begin
                                            n_pos     = w_len - 10'd1;
                                            n_running = 1'b0;
                                        end
                                    end else begin
                                        n_pos = w_pos_inc[9:0];
                                    end
                                end
                            end
                        end
                    end
                    CMD_START: begin
                        if (w_len != '0) begin
                            n_running = 1'b1;
                            n_pos     = '0;
                        end
                    end
                    CMD_STOP: begin
                        n_running = 1'b0;
                        n_pos     = '0;
                    end
                    CMD_PAUSE: begin
                        n_running = 1'b0;
                    end
                    CMD_RESUME: begin
                        if (w_len != '0) begin
                            n_running = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = S_FRAME;
            end
            S_FRAME: begin
                n_frame   = w_frame;
                n_quo     = w_frame;
                n_rem     = '0;
                n_div_cnt = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                n_rem     = w_qbit ? 9'(w_trial - {1'b0, w_fpr}) : w_trial[8:0];
                n_quo     = {r_quo[6:0], w_qbit};
                n_div_cnt = r_div_cnt + 3'd1;
                if (r_div_cnt == 3'd7) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_x_prod = 19'(r_rem[7:0]) * 19'(i_cfg.frame_width);
                n_y_prod = 19'(r_quo) * 19'(i_cfg.frame_height);
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.playing      = r_running;
                    n_out.frame_number = r_frame;
                    n_out.frame_x      = sat_xy(r_x_prod);
                    n_out.frame_y      = sat_xy(r_y_prod);
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_pos       <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_pos       <= n_pos;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_elapsed <= n_elapsed;
        r_sum     <= n_sum;
        r_frame   <= n_frame;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_div_cnt <= n_div_cnt;
        r_x_prod  <= n_x_prod;
        r_y_prod  <= n_y_prod;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hdl/sprite_frame_sequencer.sv]
// sprite_frame_sequencer: top level, configuration registers,
// decode front end with command queue and execution back end
// depends on sfs_pkg, sfs_front, sfs_back
//
//   channel   direction  handshake               payload
//   request   in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
//   result    out        o_out_valid / i_out_stall o_out_data (t_out_item)
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// each request passes through the back end in steps: accumulate, step, frame
// select, a restoring divide for row and column, multiply, output
// the front queue holds two decoded requests while the back end is busy
// synchronous active low reset clears playback state, queue and output valid
// a stalled result holds the back end in its output step
module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  sfs_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output sfs_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sfs_pkg::*;

    t_cfg     r_cfg, n_cfg;
    logic     w_q_valid;
    t_q_entry w_q_entry;
    logic     w_q_pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:    n_cfg.frame_width    = i_cfg_data[10:0];
                CFG_FRAME_HEIGHT:   n_cfg.frame_height   = i_cfg_data[10:0];
                CFG_FRAMES_PER_ROW: n_cfg.frames_per_row = i_cfg_data[8:0];
                CFG_SEQ_START:      n_cfg.seq_start      = i_cfg_data[7:0];
                CFG_SEQ_END:        n_cfg.seq_end        = i_cfg_data[7:0];
                CFG_PING_PONG:      n_cfg.ping_pong      = i_cfg_data[0];
                CFG_LOOP_ENABLE:    n_cfg.loop_enable    = i_cfg_data[0];
                CFG_FRAME_PERIOD:   n_cfg.frame_period   = i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width    <= 11'd1;
            r_cfg.frame_height   <= 11'd1;
            r_cfg.frames_per_row <= 9'd1;
            r_cfg.seq_start      <= '0;
            r_cfg.seq_end        <= '0;
            r_cfg.ping_pong      <= 1'b0;
            r_cfg.loop_enable    <= 1'b0;
            r_cfg.frame_period   <= PERIOD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    sfs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (w_q_valid),
        .o_q_entry  (w_q_entry),
        .i_q_pop    (w_q_pop)
    );

    sfs_back #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_q_entry),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
